[rtl/core/ohl_pkg.sv]
package ohl_pkg;

   localparam int CAPACITY          = 64;
   localparam int HANDLE_BITS       = 16;
   localparam int HANDLE_FIELD_BITS = 16;
   localparam int OP_BITS           = 2;
   localparam int POS_BITS          = 6;
   localparam int STATUS_BITS       = 2;
   localparam int LIST_COUNT_BITS   = 7;
   localparam int COUNT_BITS        = $clog2(CAPACITY + 1);
   localparam int WIDE_BITS         = (COUNT_BITS > POS_BITS + 1) ? COUNT_BITS : POS_BITS + 1;
   localparam int GROUP_SIZE        = 8;
   localparam int NGROUPS           = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_BITS          = NGROUPS * GROUP_SIZE;

   typedef logic [HANDLE_BITS-1:0] handle_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SWAP   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_BEYOND    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_SCAN,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic       append_en;
      logic       remove_en;
      logic       swap_en;
      handle_type handle_a;
      handle_type handle_b;
   } cell_cmd_type;

   typedef struct packed {
      logic valid;
      logic append_at;
      logic read_at;
      logic shift;
      logic last_a;
      logic last_b;
   } cell_sel_type;

endpackage

[rtl/core/ohl_cell.sv]
module ohl_cell import ohl_pkg::*; (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  cell_sel_type sel,
   input  handle_type   next_data,
   output handle_type   data,
   output logic         match_a,
   output logic         match_b,
   output handle_type   tap
);

   handle_type data_ff;
   handle_type data_in;

   always_comb begin
      priority if (cmd.append_en && sel.append_at) begin
         data_in = cmd.handle_a;
      end else if (cmd.remove_en && sel.shift) begin
         data_in = next_data;
      end else if (cmd.swap_en && sel.last_a) begin
         data_in = cmd.handle_b;
      end else if (cmd.swap_en && sel.last_b) begin
         data_in = cmd.handle_a;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign match_a = sel.valid && (data_ff == cmd.handle_a);
   assign match_b = sel.valid && (data_ff == cmd.handle_b) && (data_ff != cmd.handle_a);
   assign tap     = sel.read_at ? data_ff : '0;

endmodule

[rtl/core/ohl_scan.sv]
module ohl_scan import ohl_pkg::*; (
   input  logic                clock,
   input  logic [CAPACITY-1:0] match_a,
   input  logic [CAPACITY-1:0] match_b,
   output logic [CAPACITY-1:0] shift_sel,
   output logic [CAPACITY-1:0] last_a,
   output logic [CAPACITY-1:0] last_b,
   output logic                found_a,
   output logic                found_b
);

   logic [PAD_BITS-1:0] ma_pad;
   logic [PAD_BITS-1:0] mb_pad;
   logic [PAD_BITS-1:0] ma_ff;
   logic [PAD_BITS-1:0] mb_ff;
   logic [PAD_BITS-1:0] lpre_a_in;
   logic [PAD_BITS-1:0] lpre_a_ff;
   logic [PAD_BITS-1:0] lsuf_a_in;
   logic [PAD_BITS-1:0] lsuf_a_ff;
   logic [PAD_BITS-1:0] lsuf_b_in;
   logic [PAD_BITS-1:0] lsuf_b_ff;
   logic [NGROUPS-1:0]  grp_a_in;
   logic [NGROUPS-1:0]  grp_a_ff;
   logic [NGROUPS-1:0]  grp_b_in;
   logic [NGROUPS-1:0]  grp_b_ff;
   logic [NGROUPS-1:0]  gpre_a;
   logic [NGROUPS-1:0]  gsuf_a;
   logic [NGROUPS-1:0]  gsuf_b;
   logic [CAPACITY-1:0] shift_in;
   logic [CAPACITY-1:0] shift_ff;
   logic [CAPACITY-1:0] last_a_in;
   logic [CAPACITY-1:0] last_a_ff;
   logic [CAPACITY-1:0] last_b_in;
   logic [CAPACITY-1:0] last_b_ff;
   logic                found_a_ff;
   logic                found_b_ff;

   assign ma_pad = PAD_BITS'(match_a);
   assign mb_pad = PAD_BITS'(match_b);

   // Within each group of cells: inclusive prefix and exclusive suffix of the match bits.
   always_comb begin
      logic run_pa;
      logic run_sa;
      logic run_sb;
      for (int g = 0; g < NGROUPS; g++) begin
         run_pa = 1'b0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            run_pa = run_pa | ma_pad[g*GROUP_SIZE + k];
            lpre_a_in[g*GROUP_SIZE + k] = run_pa;
         end
         run_sa = 1'b0;
         run_sb = 1'b0;
         for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
            lsuf_a_in[g*GROUP_SIZE + k] = run_sa;
            lsuf_b_in[g*GROUP_SIZE + k] = run_sb;
            run_sa = run_sa | ma_pad[g*GROUP_SIZE + k];
            run_sb = run_sb | mb_pad[g*GROUP_SIZE + k];
         end
         grp_a_in[g] = run_pa;
         grp_b_in[g] = run_sb;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff     <= ma_pad;
      mb_ff     <= mb_pad;
      lpre_a_ff <= lpre_a_in;
      lsuf_a_ff <= lsuf_a_in;
      lsuf_b_ff <= lsuf_b_in;
      grp_a_ff  <= grp_a_in;
      grp_b_ff  <= grp_b_in;
   end

   // Across groups: exclusive prefix and suffix of the group flags.
   always_comb begin
      logic run_pa;
      logic run_sa;
      logic run_sb;
      run_pa = 1'b0;
      for (int g = 0; g < NGROUPS; g++) begin
         gpre_a[g] = run_pa;
         run_pa    = run_pa | grp_a_ff[g];
      end
      run_sa = 1'b0;
      run_sb = 1'b0;
      for (int g = NGROUPS - 1; g >= 0; g--) begin
         gsuf_a[g] = run_sa;
         gsuf_b[g] = run_sb;
         run_sa    = run_sa | grp_a_ff[g];
         run_sb    = run_sb | grp_b_ff[g];
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         shift_in[i]  = lpre_a_ff[i] | gpre_a[i / GROUP_SIZE];
         last_a_in[i] = ma_ff[i] & ~(lsuf_a_ff[i] | gsuf_a[i / GROUP_SIZE]);
         last_b_in[i] = mb_ff[i] & ~(lsuf_b_ff[i] | gsuf_b[i / GROUP_SIZE]);
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      last_a_ff  <= last_a_in;
      last_b_ff  <= last_b_in;
      found_a_ff <= |grp_a_ff;
      found_b_ff <= |grp_b_ff;
   end

   assign shift_sel = shift_ff;
   assign last_a    = last_a_ff;
   assign last_b    = last_b_ff;
   assign found_a   = found_a_ff;
   assign found_b   = found_b_ff;

endmodule

[rtl/core/ordered_handle_list.sv]
// Ordered list of up to 64 handles, kept in a row of cells, one handle per cell.
// Request channel: the block takes a word (operation, handle_a, handle_b, position)
// at a rising edge where start is high and busy is low. Operations are append,
// remove of the first equal entry, swap of the last entries equal to handle_a and
// handle_b, and read at a position.
// Response channel: exactly one word per request, shown on the rsp_ ports for one
// cycle while rsp_valid is high. It carries the status, the handle read (zero
// unless a read succeeds) and the entry count after the operation.
// Each request passes through the states S_MATCH, S_SCAN and S_APPLY. In S_MATCH,
// all cells compare against the handles and each group of eight cells forms its
// prefix and suffix flags. In S_SCAN, the group flags are combined to find the
// first and last matching cells. In S_APPLY, the cells are updated and the
// response is registered. The response is then shown in S_IDLE; busy is low in
// that cycle, so a new request can be taken while the response is shown.
// The receiver cannot stall: a response is gone after its one cycle.
// Reset clears the entry count and the control state; the cell contents are left
// as they are and are never read before they are written.
module ordered_handle_list import ohl_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [OP_BITS-1:0]           req_operation,
   input  logic [HANDLE_FIELD_BITS-1:0] req_handle_a,
   input  logic [HANDLE_FIELD_BITS-1:0] req_handle_b,
   input  logic [POS_BITS-1:0]          req_position,
   output logic                         rsp_valid,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic [HANDLE_FIELD_BITS-1:0] rsp_handle_out,
   output logic [LIST_COUNT_BITS-1:0]   rsp_list_count
);

   state_type                    state_ff;
   state_type                    state_in;
   logic                         accept;
   op_type                       op_ff;
   handle_type                   ha_ff;
   handle_type                   hb_ff;
   logic [POS_BITS-1:0]          pos_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   logic [COUNT_BITS-1:0]        count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   status_type                   rsp_status_ff;
   status_type                   rsp_status_in;
   logic [HANDLE_FIELD_BITS-1:0] rsp_handle_ff;
   logic [HANDLE_FIELD_BITS-1:0] rsp_handle_in;
   logic [LIST_COUNT_BITS-1:0]   rsp_count_ff;
   logic [LIST_COUNT_BITS-1:0]   rsp_count_in;
   logic                         full;
   logic                         read_ok;
   handle_type                   read_or;
   cell_cmd_type                 cell_cmd;
   cell_sel_type                 cell_sel [CAPACITY];
   handle_type                   cell_data [CAPACITY];
   handle_type                   cell_next [CAPACITY];
   handle_type                   cell_tap [CAPACITY];
   logic [CAPACITY-1:0]          match_a;
   logic [CAPACITY-1:0]          match_b;
   logic [CAPACITY-1:0]          shift_sel;
   logic [CAPACITY-1:0]          last_a;
   logic [CAPACITY-1:0]          last_b;
   logic                         found_a;
   logic                         found_b;

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            state_in = start ? S_MATCH : S_IDLE;
         end
         S_MATCH: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy                = (state_ff != S_IDLE);
      accept              = start && (state_ff == S_IDLE);
      cell_cmd.handle_a   = ha_ff;
      cell_cmd.handle_b   = hb_ff;
      cell_cmd.append_en  = (state_ff == S_APPLY) && (op_ff == OP_APPEND) && !full;
      cell_cmd.remove_en  = (state_ff == S_APPLY) && (op_ff == OP_REMOVE) && found_a;
      cell_cmd.swap_en    = (state_ff == S_APPLY) && (op_ff == OP_SWAP) && found_a && found_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_operation);
         ha_ff  <= HANDLE_BITS'(req_handle_a);
         hb_ff  <= HANDLE_BITS'(req_handle_b);
         pos_ff <= req_position;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      always_comb begin
         cell_sel[i].valid     = COUNT_BITS'(i) < count_ff;
         cell_sel[i].append_at = COUNT_BITS'(i) == count_ff;
         cell_sel[i].read_at   = WIDE_BITS'(i) == WIDE_BITS'(pos_ff);
         cell_sel[i].shift     = shift_sel[i];
         cell_sel[i].last_a    = last_a[i];
         cell_sel[i].last_b    = last_b[i];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign cell_next[i] = '0;
      end else begin : g_mid
         assign cell_next[i] = cell_data[i+1];
      end

      ohl_cell u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .sel       (cell_sel[i]),
         .next_data (cell_next[i]),
         .data      (cell_data[i]),
         .match_a   (match_a[i]),
         .match_b   (match_b[i]),
         .tap       (cell_tap[i])
      );
   end

   ohl_scan u_scan (
      .clock     (clock),
      .match_a   (match_a),
      .match_b   (match_b),
      .shift_sel (shift_sel),
      .last_a    (last_a),
      .last_b    (last_b),
      .found_a   (found_a),
      .found_b   (found_b)
   );

   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | cell_tap[i];
      end
   end

   assign full    = (count_ff == COUNT_BITS'(CAPACITY));
   assign read_ok = WIDE_BITS'(pos_ff) < WIDE_BITS'(count_ff);

   always_comb begin
      count_in      = count_ff;
      rsp_status_in = STATUS_OK;
      rsp_handle_in = '0;
      rsp_valid_in  = (state_ff == S_APPLY);
      if (state_ff == S_APPLY) begin
         unique case (op_ff)
            OP_APPEND: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (found_a) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            end
            OP_SWAP: begin
               if (!(found_a && found_b)) begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            end
            OP_READ: begin
               if (read_ok) begin
                  rsp_handle_in = HANDLE_FIELD_BITS'(read_or);
               end else begin
                  rsp_status_in = STATUS_BEYOND;
               end
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
      rsp_count_in = LIST_COUNT_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_list_count = rsp_count_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("Entry count exceeds the capacity.");

   a_count_only_in_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_APPLY) |=> (count_ff == $past(count_ff)))
      else $error("Entry count changed outside the update cycle.");

   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_APPLY))
      else $error("Response word shown without an update cycle before it.");

   a_last_a_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> $onehot0(last_a))
      else $error("More than one cell marked as the last match of handle_a.");

   a_last_b_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> $onehot0(last_b))
      else $error("More than one cell marked as the last match of handle_b.");
`endif

endmodule
